[design/dbt_pkg.sv]
// ----------------------------------------------------------------------------
// dbt_pkg: shared definitions for the distance and bearing block
// Datapath widths, the arctangent table, the pipeline payload type and the
// elaboration-time gain compensation constant of the CORDIC.
// ----------------------------------------------------------------------------
package dbt_pkg;

    localparam int COORD_WIDTH_DEF  = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    // Vector datapath: coordinates are normalized to 2^58, so 62 bits hold
    // every intermediate value of the micro-rotations at any coordinate width up to 58 bits.
    localparam int XY_W      = 62;
    localparam int NORM_BITS = 58;
    localparam int ANG_W     = 32;
    localparam int BEAR_W    = 16;
    localparam int K_W       = 30;

    localparam logic [ANG_W-1:0] ANGLE_PI = 32'h8000_0000;

    // atan(2^-i) in units where 2^31 stands for pi, rounded to nearest.
    localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [ANG_W-1:0]       z;
    } t_vec;

    // Reciprocal of the CORDIC gain in Q30, evaluated at elaboration only.
    function automatic logic [63:0] dbt_gain_comp(input int steps);
        logic [63:0] g;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] s;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        int          i;
        g = 64'd1 << 60;
        for (i = 0; i < 32; i++) begin
            if (i < steps) begin
                g = g + (g >> (2 * i));
            end
        end
        n = g;
        r = '0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (b > n) begin
                b = b >> 2;
            end
        end
        for (i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        s = (r == 64'd0) ? 64'd1 : r;
        num = (64'd1 << 60) + (s >> 1);
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= s) begin
                rem  = rem - s;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

endpackage

[design/distance_and_bearing_to_target.sv]
// ----------------------------------------------------------------------------
// distance_and_bearing_to_target: range and bearing from two positions
// Pipelined CORDIC in vectoring mode with gain compensation.
// ----------------------------------------------------------------------------
// How to use this block:
// An item is a pair of positions, current and target, in signed fixed point
// with 8 fractional bits. It is taken at a rising clock edge where start is
// high and busy is low. The result, the Euclidean distance and the bearing
// atan2(dx, dy) measured from +y toward +x (32768 stands for pi), appears on
// o_distance and o_bearing for exactly one cycle, flagged by o_done.
// Two front stages form the difference and fold it into the right half
// plane, one stage per micro-rotation drives it onto the axis, and two
// stages apply the gain multiply and rounding.
// Throughput is one item every cycle; the rotation stages are a fixed-depth
// pipeline, so every item takes the same path and results leave in order.
// The receiver cannot hold results off, so nothing ever backs up.
// busy is high only during reset and the cycle after; reset discards every
// item in flight and no result of it appears. A zero difference vector
// gives distance 0 and bearing 0.
// ----------------------------------------------------------------------------
module distance_and_bearing_to_target #(
    parameter int COORD_WIDTH  = dbt_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = dbt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_WIDTH-1:0]     i_from_x,
    input  logic signed [COORD_WIDTH-1:0]     i_from_y,
    input  logic signed [COORD_WIDTH-1:0]     i_to_x,
    input  logic signed [COORD_WIDTH-1:0]     i_to_y,
    output logic                              o_done,
    output logic [COORD_WIDTH:0]              o_distance,
    output logic signed [dbt_pkg::BEAR_W-1:0] o_bearing
);
    import dbt_pkg::*;

    logic r_busy;
    logic accept;
    logic chain_valid [CORDIC_STEPS+1];
    t_vec chain_vec   [CORDIC_STEPS+1];

    // Busy covers reset only; the pipeline itself never refuses an item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    dbt_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_from_x (i_from_x),
        .i_from_y (i_from_y),
        .i_to_x   (i_to_x),
        .i_to_y   (i_to_y),
        .o_valid  (chain_valid[0]),
        .o_vec    (chain_vec[0])
    );

    // One registered micro-rotation per CORDIC step.
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
        dbt_rot_stage #(
            .STAGE(g)
        ) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_vec   (chain_vec[g]),
            .o_valid (chain_valid[g+1]),
            .o_vec   (chain_vec[g+1])
        );
    end

    dbt_scale #(
        .COORD_WIDTH (COORD_WIDTH),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (chain_valid[CORDIC_STEPS]),
        .i_vec      (chain_vec[CORDIC_STEPS]),
        .o_valid    (o_done),
        .o_distance (o_distance),
        .o_bearing  (o_bearing)
    );

endmodule

[design/dbt_front.sv]
// ----------------------------------------------------------------------------
// dbt_front: difference vector and half-plane fold
// Two register stages: the coordinate difference, then the normalized and
// folded CORDIC start vector with its starting angle.
// ----------------------------------------------------------------------------
module dbt_front #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_from_x,
    input  logic signed [COORD_WIDTH-1:0] i_from_y,
    input  logic signed [COORD_WIDTH-1:0] i_to_x,
    input  logic signed [COORD_WIDTH-1:0] i_to_y,
    output logic                          o_valid,
    output dbt_pkg::t_vec                 o_vec
);
    import dbt_pkg::*;

    localparam int GUARD = NORM_BITS - COORD_WIDTH;

    logic                        r_dvalid;
    logic signed [COORD_WIDTH:0] r_dx;
    logic signed [COORD_WIDTH:0] r_dy;
    logic                        n_zero;
    logic signed [XY_W-1:0]      n_x;
    logic signed [XY_W-1:0]      n_y;
    logic                        r_valid;
    t_vec                        r_vec;
    t_vec                        n_vec;

    // Stage 1: exact difference, one bit wider than the coordinates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= 1'b0;
        end else begin
            r_dvalid <= i_valid;
        end
        r_dx <= (COORD_WIDTH+1)'(i_to_x) - (COORD_WIDTH+1)'(i_from_x);
        r_dy <= (COORD_WIDTH+1)'(i_to_y) - (COORD_WIDTH+1)'(i_from_y);
    end

    // Stage 2: the CORDIC x axis takes dy, the y axis takes dx; a vector in
    // the lower half plane is negated and starts at pi.
    always_comb begin
        n_zero = (r_dx == '0) && (r_dy == '0);
        n_x    = XY_W'(r_dy) <<< GUARD;
        n_y    = XY_W'(r_dx) <<< GUARD;
        n_vec.zero = n_zero;
        if (n_x < 0) begin
            n_vec.x = -n_x;
            n_vec.y = -n_y;
            n_vec.z = ANGLE_PI;
        end else begin
            n_vec.x = n_x;
            n_vec.y = n_y;
            n_vec.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_dvalid;
        end
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

[design/dbt_rot_stage.sv]
// ----------------------------------------------------------------------------
// dbt_rot_stage: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-STAGE) and registers the result.
// ----------------------------------------------------------------------------
module dbt_rot_stage #(
    parameter int STAGE = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dbt_pkg::t_vec i_vec,
    output logic          o_valid,
    output dbt_pkg::t_vec o_vec
);
    import dbt_pkg::*;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   r_valid;
    t_vec                   r_vec;
    t_vec                   n_vec;

    always_comb begin
        xs = i_vec.x >>> STAGE;
        ys = i_vec.y >>> STAGE;
        n_vec.zero = i_vec.zero;
        if (!i_vec.y[XY_W-1]) begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + ATAN_TAB[STAGE];
        end else begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - ATAN_TAB[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

[design/dbt_scale.sv]
// ----------------------------------------------------------------------------
// dbt_scale: gain compensation and output rounding
// Multiplies the grown length by the inverse CORDIC gain in two 30-bit
// halves, then rounds, saturates and forms the 16-bit bearing.
// ----------------------------------------------------------------------------
module dbt_scale #(
    parameter int COORD_WIDTH  = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  dbt_pkg::t_vec                 i_vec,
    output logic                          o_valid,
    output logic [COORD_WIDTH:0]          o_distance,
    output logic signed [dbt_pkg::BEAR_W-1:0] o_bearing
);
    import dbt_pkg::*;

    localparam int GUARD  = NORM_BITS - COORD_WIDTH;
    localparam int DIST_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * K_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [K_W-1:0]   K_GAIN = K_W'(dbt_gain_comp(CORDIC_STEPS));
    localparam logic [SUM_W-1:0] HALF   = SUM_W'(1) << (GUARD - 1);
    localparam logic [SUM_W-1:0] D_MAX  = SUM_W'({DIST_W{1'b1}});

    logic              r_mvalid;
    logic [PROD_W-1:0] r_p_hi;
    logic [PROD_W-1:0] r_p_lo;
    logic [ANG_W-1:0]  r_z;
    logic              r_zero;
    logic [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]  n_dist;
    logic [ANG_W-1:0]  n_zr;
    logic              r_valid;
    logic [DIST_W-1:0] r_distance;
    logic [BEAR_W-1:0] r_bearing;

    // Stage 1: the final x is nonnegative and below 2^60.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else begin
            r_mvalid <= i_valid;
        end
        r_p_hi <= PROD_W'(i_vec.x[2*K_W-1:K_W]) * PROD_W'(K_GAIN);
        r_p_lo <= PROD_W'(i_vec.x[K_W-1:0]) * PROD_W'(K_GAIN);
        r_z    <= i_vec.z;
        r_zero <= i_vec.zero;
    end

    always_comb begin
        n_sum  = SUM_W'(r_p_hi) + SUM_W'(r_p_lo >> K_W) + HALF;
        n_dist = n_sum >> GUARD;
        n_zr   = r_z + ANG_W'(32'h0000_8000);
    end

    // Stage 2: round half up, saturate, and force zero for a zero vector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_mvalid;
        end
        if (r_zero) begin
            r_distance <= '0;
            r_bearing  <= '0;
        end else begin
            r_distance <= (n_dist > D_MAX) ? DIST_W'(D_MAX) : DIST_W'(n_dist);
            r_bearing  <= n_zr[ANG_W-1:ANG_W-BEAR_W];
        end
    end

    assign o_valid    = r_valid;
    assign o_distance = r_distance;
    assign o_bearing  = r_bearing;

endmodule

[design/dbt_checker.sv]
// ----------------------------------------------------------------------------
// dbt_checker: port-level checks for the distance and bearing block
// Watches the command and result ports for latency, spurious results and the
// zero-vector case.
// ----------------------------------------------------------------------------
module dbt_checker #(
    parameter int COORD_WIDTH = 24,
    parameter int LATENCY     = 20
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic signed [COORD_WIDTH-1:0]     i_from_x,
    input logic signed [COORD_WIDTH-1:0]     i_from_y,
    input logic signed [COORD_WIDTH-1:0]     i_to_x,
    input logic signed [COORD_WIDTH-1:0]     i_to_y,
    input logic                              o_done,
    input logic [COORD_WIDTH:0]              o_distance,
    input logic signed [dbt_pkg::BEAR_W-1:0] o_bearing
);
    import dbt_pkg::*;

    logic acc;
    assign acc = start && !busy;

    // Every accepted item yields its result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##LATENCY o_done)
        else $error("result missing after the pipeline latency");

    // No result appears without an item accepted the latency before.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(acc, LATENCY))
        else $error("result without a matching item");

    // Equal positions give distance 0 and bearing 0.
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_from_x == i_to_x) && (i_from_y == i_to_y))
        |-> ##LATENCY ((o_distance == '0) && (o_bearing == '0)))
        else $error("zero vector gave a nonzero result");

    // A zero distance only comes from a zero vector, whose bearing is 0.
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_distance == '0)) |-> (o_bearing == '0))
        else $error("zero distance with a nonzero bearing");

endmodule

bind distance_and_bearing_to_target dbt_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .LATENCY    (CORDIC_STEPS + 4)
) u_dbt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_from_x   (i_from_x),
    .i_from_y   (i_from_y),
    .i_to_x     (i_to_x),
    .i_to_y     (i_to_y),
    .o_done     (o_done),
    .o_distance (o_distance),
    .o_bearing  (o_bearing)
);
